FILE: hw/rtl/va3_pkg.sv
// Shared constants, types and saturation helper for the vector ALU.
`default_nettype none
package va3_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OP_BITS     = 4;
  localparam int NUM_LANES   = 3;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int QUO_BITS    = WORD_BITS + FRAC_BITS;
  localparam int TERM_BITS   = PROD_BITS - FRAC_BITS + 1;
  localparam int SUM_BITS    = TERM_BITS + 1;
  localparam int SQRT_STAGES = WORD_BITS;
  localparam int DIV_STAGES  = QUO_BITS;
  localparam int PIPE_STAGES = 2 + SQRT_STAGES + DIV_STAGES;

  localparam int IN_RAW   = OP_BITS + 7 * WORD_BITS;
  localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW  = 4 * WORD_BITS + 2;
  localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [OP_BITS-1:0] OP_ADD   = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_SUB   = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_MUL   = OP_BITS'(2);
  localparam logic [OP_BITS-1:0] OP_DIV   = OP_BITS'(3);
  localparam logic [OP_BITS-1:0] OP_DOT   = OP_BITS'(4);
  localparam logic [OP_BITS-1:0] OP_CROSS = OP_BITS'(5);
  localparam logic [OP_BITS-1:0] OP_MIN   = OP_BITS'(6);
  localparam logic [OP_BITS-1:0] OP_MAX   = OP_BITS'(7);
  localparam logic [OP_BITS-1:0] OP_LEN   = OP_BITS'(8);
  localparam logic [OP_BITS-1:0] OP_NORM  = OP_BITS'(9);
  localparam logic [OP_BITS-1:0] OP_SCALE = OP_BITS'(10);

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 ov;
  } sat_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 ov;
    logic                 dz;
  } lane_res_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic signed [TERM_BITS-1:0] term;
    logic [WORD_BITS-1:0]        amag;
    logic                        aneg;
    logic [WORD_BITS-1:0]        bmag;
    logic                        bneg;
  } lane_st_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic signed [TERM_BITS-1:0] term;
    logic                        qneg;
    logic                        dz;
    logic [WORD_BITS-1:0]        divisor;
    logic [WORD_BITS-1:0]        rem;
    logic [QUO_BITS-1:0]         numq;
  } div_st_t;

  function automatic sat_t sat_word(input logic signed [SUM_BITS-1:0] v);
    sat_t r;
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r.value = {1'b0, {(WORD_BITS-1){1'b1}}};
      r.ov    = 1'b1;
    end else if (v < lo) begin
      r.value = {1'b1, {(WORD_BITS-1){1'b0}}};
      r.ov    = 1'b1;
    end else begin
      r.value = v[WORD_BITS-1:0];
      r.ov    = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/vector3_alu_top.sv
// Top level of the three-component Q16.16 vector ALU.
`default_nettype none
// Three-component vector ALU, signed Q16.16. Takes one request per clock while
// not stalled and returns one result per request, in order. Every request
// travels the same pipeline from input acceptance to a valid output: two
// multiply/term stages, a 32-stage square-root pipeline (one root bit per
// stage, shared by all lanes for length and normalize) and a 48-stage
// restoring divider per lane (one quotient bit per stage). Three identical
// lanes handle x, y and z; a merge stage forms the dot/length scalar, the
// saturation and divide-by-zero flags and loads the output register.
// Backpressure stalls the whole pipeline only when the output register is
// full, not taken, and the last stage holds a request; bubbles keep moving.
// Division by zero or normalizing a zero vector yields zero and sets
// divide_by_zero; any saturated value sets overflow. Codes 11..15 give zeros.
module vector3_alu_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // operation[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scale_factor (32 b each), zero pad
  input  logic [va3_pkg::IN_BITS-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // result_x, result_y, result_z, result_scalar (32 b each), overflow,
  // divide_by_zero, zero pad
  output logic [va3_pkg::OUT_BITS-1:0] out_tdata
);
  import va3_pkg::*;

  logic                        en;
  logic                        accept;
  logic [OP_BITS-1:0]          op_in;
  logic signed [WORD_BITS-1:0] a_v [NUM_LANES];
  logic signed [WORD_BITS-1:0] b_v [NUM_LANES];
  logic signed [WORD_BITS-1:0] k_v;

  // control line, one entry per pipeline stage
  logic                        vld_r [PIPE_STAGES];
  logic [OP_BITS-1:0]          op_r  [PIPE_STAGES];

  logic                        out_valid_r;
  logic [OUT_BITS-1:0]         out_data_r;

  // advance unless the output slot is stuck and the last stage is occupied
  assign en        = !vld_r[PIPE_STAGES-1] || !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  assign op_in = in_tdata[OP_BITS-1:0];
  assign k_v   = in_tdata[OP_BITS + 6*WORD_BITS +: WORD_BITS];

  logic signed [PROD_BITS-1:0] prod_v [NUM_LANES];
  lane_res_t                   res_v  [NUM_LANES];
  logic [WORD_BITS-1:0]        root;

  // lanes; cross product pulls operands from the two other components
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam int IJ = (i + 1) % NUM_LANES;
    localparam int IK = (i + 2) % NUM_LANES;
    logic signed [WORD_BITS-1:0] pa;
    logic signed [WORD_BITS-1:0] pb;

    assign a_v[i] = in_tdata[OP_BITS + i*WORD_BITS +: WORD_BITS];
    assign b_v[i] = in_tdata[OP_BITS + (NUM_LANES+i)*WORD_BITS +: WORD_BITS];

    always_comb begin
      unique case (op_in)
        OP_CROSS: begin
          pa = a_v[IJ];
          pb = b_v[IK];
        end
        OP_SCALE: begin
          pa = a_v[i];
          pb = k_v;
        end
        OP_LEN, OP_NORM: begin
          pa = a_v[i];
          pb = a_v[i];
        end
        default: begin
          pa = a_v[i];
          pb = b_v[i];
        end
      endcase
    end

    va3_lane u_lane (
      .clk  (clk),
      .en   (en),
      .op   (op_in),
      .a    (a_v[i]),
      .b    (b_v[i]),
      .pa   (pa),
      .pb   (pb),
      .qa   (a_v[IK]),
      .qb   (b_v[IJ]),
      .len  (root),
      .prod (prod_v[i]),
      .res  (res_v[i])
    );
  end

  // stage 2: sum of squares for the root, dot product from floored terms
  logic [PROD_BITS-1:0]       sumsq_r;
  logic signed [SUM_BITS-1:0] dot_r;
  logic signed [SUM_BITS-1:0] dot_d_r [SQRT_STAGES + DIV_STAGES];
  logic [WORD_BITS-1:0]       len_d_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq_r <= unsigned'(prod_v[0]) + unsigned'(prod_v[1]) + unsigned'(prod_v[2]);
      dot_r   <= SUM_BITS'(signed'(prod_v[0][PROD_BITS-1:FRAC_BITS]))
               + SUM_BITS'(signed'(prod_v[1][PROD_BITS-1:FRAC_BITS]))
               + SUM_BITS'(signed'(prod_v[2][PROD_BITS-1:FRAC_BITS]));
      dot_d_r[0] <= dot_r;
      for (int i = 1; i < SQRT_STAGES + DIV_STAGES; i++) begin
        dot_d_r[i] <= dot_d_r[i-1];
      end
      len_d_r[0] <= root;
      for (int i = 1; i < DIV_STAGES; i++) begin
        len_d_r[i] <= len_d_r[i-1];
      end
    end
  end

  va3_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sumsq_r),
    .root     (root)
  );

  // control line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= accept;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= op_in;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        op_r[i] <= op_r[i-1];
      end
    end
  end

  // merge: scalar result and flags
  logic [OP_BITS-1:0] op_o;
  sat_t               scal;
  logic               ov_o;
  logic               dz_o;

  assign op_o = op_r[PIPE_STAGES-1];

  always_comb begin
    unique case (op_o)
      OP_DOT:  scal = sat_word(dot_d_r[SQRT_STAGES + DIV_STAGES - 1]);
      OP_LEN:  scal = sat_word({{(SUM_BITS-WORD_BITS){1'b0}}, len_d_r[DIV_STAGES-1]});
      default: scal = '0;
    endcase
  end

  assign ov_o = res_v[0].ov | res_v[1].ov | res_v[2].ov | scal.ov;
  assign dz_o = res_v[0].dz | res_v[1].dz | res_v[2].dz;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[PIPE_STAGES-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[PIPE_STAGES-1]) begin
      out_data_r <= OUT_BITS'({dz_o, ov_o, scal.value,
                               res_v[2].value, res_v[1].value, res_v[0].value});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a held result with a full last stage must block new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && vld_r[PIPE_STAGES-1]) |-> !in_tready)
    else $error("input accepted while pipeline is stalled");

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");

  // divide-by-zero only comes from vector ops, so the scalar is zero
  a_dz_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[4*WORD_BITS+1]) |-> (out_data_r[4*WORD_BITS-1 -: WORD_BITS] == '0))
    else $error("divide_by_zero with nonzero scalar");

endmodule
`default_nettype wire

FILE: hw/rtl/va3_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module va3_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [va3_pkg::PROD_BITS-1:0]  radicand,
  output logic [va3_pkg::WORD_BITS-1:0]  root
);
  import va3_pkg::*;

  localparam int RW = WORD_BITS + 2;

  logic [RW-1:0]        rem_r    [SQRT_STAGES];
  logic [WORD_BITS-1:0] root_r   [SQRT_STAGES];
  logic [PROD_BITS-1:0] nsh_r    [SQRT_STAGES];
  logic [RW-1:0]        rem_nxt  [SQRT_STAGES];
  logic [WORD_BITS-1:0] root_nxt [SQRT_STAGES];
  logic [PROD_BITS-1:0] nsh_nxt  [SQRT_STAGES];

  always_comb begin
    logic [RW-1:0]        rem_in;
    logic [WORD_BITS-1:0] root_in;
    logic [PROD_BITS-1:0] nsh_in;
    logic [RW+1:0]        r4;
    logic [RW+1:0]        trial;
    logic                 ge;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        rem_in  = '0;
        root_in = '0;
        nsh_in  = radicand;
      end else begin
        rem_in  = rem_r[s-1];
        root_in = root_r[s-1];
        nsh_in  = nsh_r[s-1];
      end
      // bring down the next two radicand bits, try root*4+1
      r4    = {rem_in, nsh_in[PROD_BITS-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      ge    = (r4 >= trial);
      rem_nxt[s]  = ge ? RW'(r4 - trial) : RW'(r4);
      root_nxt[s] = {root_in[WORD_BITS-2:0], ge};
      nsh_nxt[s]  = {nsh_in[PROD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        nsh_r[s]  <= nsh_nxt[s];
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/va3_lane.sv
// One vector component lane: multipliers, term stage, delay and restoring divider.
`default_nettype none
module va3_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [va3_pkg::OP_BITS-1:0]         op,
  input  logic signed [va3_pkg::WORD_BITS-1:0] a,
  input  logic signed [va3_pkg::WORD_BITS-1:0] b,
  input  logic signed [va3_pkg::WORD_BITS-1:0] pa,
  input  logic signed [va3_pkg::WORD_BITS-1:0] pb,
  input  logic signed [va3_pkg::WORD_BITS-1:0] qa,
  input  logic signed [va3_pkg::WORD_BITS-1:0] qb,
  input  logic [va3_pkg::WORD_BITS-1:0]        len,
  output logic signed [va3_pkg::PROD_BITS-1:0] prod,
  output va3_pkg::lane_res_t                  res
);
  import va3_pkg::*;

  // stage 1: products and the simple elementwise ops
  logic [OP_BITS-1:0]          op1_r;
  logic signed [PROD_BITS-1:0] p1_r;
  logic signed [PROD_BITS-1:0] q1_r;
  logic signed [WORD_BITS:0]   simple1_r;
  logic signed [WORD_BITS:0]   simple_nxt;
  logic [WORD_BITS-1:0]        amag1_r;
  logic [WORD_BITS-1:0]        bmag1_r;
  logic                        aneg1_r;
  logic                        bneg1_r;

  always_comb begin
    unique case (op)
      OP_ADD:  simple_nxt = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      OP_SUB:  simple_nxt = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      OP_MIN:  simple_nxt = (a < b) ? {a[WORD_BITS-1], a} : {b[WORD_BITS-1], b};
      OP_MAX:  simple_nxt = (a > b) ? {a[WORD_BITS-1], a} : {b[WORD_BITS-1], b};
      default: simple_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= op;
      p1_r      <= pa * pb;
      q1_r      <= qa * qb;
      simple1_r <= simple_nxt;
      aneg1_r   <= a[WORD_BITS-1];
      bneg1_r   <= b[WORD_BITS-1];
      amag1_r   <= a[WORD_BITS-1] ? unsigned'(~a + 1'b1) : unsigned'(a);
      bmag1_r   <= b[WORD_BITS-1] ? unsigned'(~b + 1'b1) : unsigned'(b);
    end
  end

  assign prod = p1_r;

  // stage 2: floored product terms
  logic [QUO_BITS-1:0]         fp;
  logic [QUO_BITS-1:0]         fq;
  logic signed [TERM_BITS-1:0] term_nxt;
  lane_st_t                    st2_r;

  assign fp = p1_r[PROD_BITS-1:FRAC_BITS];
  assign fq = q1_r[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    unique case (op1_r)
      OP_MUL, OP_SCALE: term_nxt = {fp[QUO_BITS-1], fp};
      OP_CROSS:         term_nxt = {fp[QUO_BITS-1], fp} - {fq[QUO_BITS-1], fq};
      OP_ADD, OP_SUB, OP_MIN, OP_MAX:
        term_nxt = {{(TERM_BITS-WORD_BITS-1){simple1_r[WORD_BITS]}}, simple1_r};
      default:          term_nxt = '0;
    endcase
  end

  // wait here while the shared root pipeline runs
  lane_st_t dly_r [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r.op   <= op1_r;
      st2_r.term <= term_nxt;
      st2_r.amag <= amag1_r;
      st2_r.aneg <= aneg1_r;
      st2_r.bmag <= bmag1_r;
      st2_r.bneg <= bneg1_r;
      dly_r[0]   <= st2_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // divider: |a| * 2^FRAC over |b| or the vector length
  lane_st_t tail;
  div_st_t  div_start;
  logic     is_div;
  div_st_t  div_r   [DIV_STAGES];
  div_st_t  div_nxt [DIV_STAGES];

  assign tail   = dly_r[SQRT_STAGES-1];
  assign is_div = (tail.op == OP_DIV);

  always_comb begin
    div_start.op      = tail.op;
    div_start.term    = tail.term;
    div_start.divisor = is_div ? tail.bmag : len;
    div_start.qneg    = is_div ? (tail.aneg ^ tail.bneg) : tail.aneg;
    div_start.dz      = (is_div || (tail.op == OP_NORM)) && (div_start.divisor == '0);
    div_start.rem     = '0;
    div_start.numq    = {tail.amag, {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    div_st_t            cur;
    logic [WORD_BITS:0] r2;
    logic               ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        cur = div_start;
      end else begin
        cur = div_r[s-1];
      end
      r2 = {cur.rem, cur.numq[QUO_BITS-1]};
      ge = (r2 >= {1'b0, cur.divisor});
      div_nxt[s]      = cur;
      div_nxt[s].rem  = ge ? WORD_BITS'(r2 - {1'b0, cur.divisor}) : r2[WORD_BITS-1:0];
      div_nxt[s].numq = {cur.numq[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        div_r[s] <= div_nxt[s];
      end
    end
  end

  // lane result
  div_st_t                    last;
  logic signed [SUM_BITS-1:0] mag_ext;
  logic signed [SUM_BITS-1:0] quo;
  logic signed [SUM_BITS-1:0] term_ext;
  sat_t                       sat_q;
  sat_t                       sat_t_v;

  assign last     = div_r[DIV_STAGES-1];
  assign mag_ext  = {{(SUM_BITS-QUO_BITS){1'b0}}, last.numq};
  assign quo      = last.qneg ? -mag_ext : mag_ext;
  assign term_ext = {{(SUM_BITS-TERM_BITS){last.term[TERM_BITS-1]}}, last.term};
  assign sat_q    = sat_word(quo);
  assign sat_t_v  = sat_word(term_ext);

  always_comb begin
    unique case (last.op)
      OP_DIV, OP_NORM: begin
        res.value = last.dz ? '0 : sat_q.value;
        res.ov    = last.dz ? 1'b0 : sat_q.ov;
        res.dz    = last.dz;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_CROSS, OP_MIN, OP_MAX, OP_SCALE: begin
        res.value = sat_t_v.value;
        res.ov    = sat_t_v.ov;
        res.dz    = 1'b0;
      end
      default: begin
        res.value = '0;
        res.ov    = 1'b0;
        res.dz    = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire
